FILE: rtl/ukrt_pkg.sv
// Shared types and codes for the unique key record table.
// No dependencies; imported by ukrt_cell, unique_key_record_table and the bench.
package ukrt_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int CNTO_W  = 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic               func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNTO_W-1:0] count_after;
  } out_word_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic               compare;
    logic               append;
    logic               shift;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: rtl/ukrt_cell.sv
// One table slot: stored key/value, match flag, and shift-down from upper neighbor.
// Depends on ukrt_pkg.
module ukrt_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ukrt_pkg::cell_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]             count,
  input  logic [CNT_W-1:0]             hit_idx,
  input  logic [ukrt_pkg::KEY_W-1:0]   up_key,
  input  logic [ukrt_pkg::VALUE_W-1:0] up_value,
  output logic [ukrt_pkg::KEY_W-1:0]   key,
  output logic [ukrt_pkg::VALUE_W-1:0] value,
  output logic                         match
);
  import ukrt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic occupied;

  assign occupied = MY_IDX < count;

  always_ff @(posedge clk) begin
    if (ctrl.append && (MY_IDX == count)) begin
      key   <= ctrl.key;
      value <= ctrl.value;
    end else if (ctrl.shift && (MY_IDX >= hit_idx)) begin
      key   <= up_key;
      value <= up_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.compare) begin
      match <= occupied && (key == ctrl.key);
    end
  end

endmodule

FILE: rtl/unique_key_record_table.sv
// Top level of the unique key record table: sequencer, hit encoder, row of cells.
// Depends on ukrt_pkg and ukrt_cell.
//
// Usage:
//   Command channel: raise start with cmd (func, key, value); the word is taken
//   at a clock edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with result (status, count_after).
//   The receiver cannot stall; each result is valid for exactly that cycle.
// Sequence:
//   Take edge -> compare (all cells at once) -> hit encode -> apply/update.
//   busy is high from the take edge until done rises, so no new command is
//   taken while one is in flight; the next start may be taken in the same
//   cycle done is high. The order is set by the three-step sequence: registered
//   per-cell compare, registered one-hot to index encode of the match flags,
//   then the append or shift-down pass through the row.
// Reset:
//   rst (synchronous) empties the table: count goes to zero, no result is
//   pending. Stored keys and values keep whatever they held; only slots below
//   the count are ever compared, so stale contents are never seen.
module unique_key_record_table #(
  parameter int CAPACITY = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ukrt_pkg::in_word_t   cmd,
  output logic                 busy,
  output logic                 done,
  output ukrt_pkg::out_word_t  result
);
  import ukrt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t state, state_next;

  in_word_t         cmd_reg;
  logic [CNT_W-1:0] count, count_next;
  logic             hit;
  logic [CNT_W-1:0] hit_idx;
  logic [CNT_W-1:0] enc_idx;
  logic             enc_hit;
  logic             full;

  logic [STAT_W-1:0] status_next;
  logic              done_next;
  cell_ctrl_t        ctrl;

  logic [KEY_W-1:0]   cell_key   [CAPACITY];
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [KEY_W-1:0]   up_key     [CAPACITY];
  logic [VALUE_W-1:0] up_value   [CAPACITY];
  logic [CAPACITY-1:0] match;

  assign busy = (state != S_IDLE);
  assign full = (count >= CAP_CNT);

  // row of cells; top cell takes don't-care data on shift (lands beyond count)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_top
      assign up_key[i]   = '0;
      assign up_value[i] = '0;
    end else begin : g_mid
      assign up_key[i]   = cell_key[i+1];
      assign up_value[i] = cell_value[i+1];
    end

    ukrt_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .count    (count),
      .hit_idx  (hit_idx),
      .up_key   (up_key[i]),
      .up_value (up_value[i]),
      .key      (cell_key[i]),
      .value    (cell_value[i]),
      .match    (match[i])
    );
  end

  // keys are unique among occupied slots, so match is one-hot or zero
  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      enc_idx = enc_idx | (match[i] ? CNT_W'(i) : '0);
    end
    enc_hit = |match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_reg <= cmd;
    end
    if (state == S_ENC) begin
      hit     <= enc_hit;
      hit_idx <= enc_idx;
    end
    if (done_next) begin
      result.status      <= status_next;
      result.count_after <= CNTO_W'(count_next);
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    done_next    = 1'b0;
    status_next  = ST_NOTFOUND;
    ctrl.compare = 1'b0;
    ctrl.append  = 1'b0;
    ctrl.shift   = 1'b0;
    ctrl.key     = cmd_reg.key;
    ctrl.value   = cmd_reg.value;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.compare = 1'b1;
        state_next   = S_ENC;
      end
      S_ENC: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (cmd_reg.func == FUNC_INSERT) begin
          // full check wins over duplicate check
          priority if (full) begin
            status_next = ST_FULL;
          end else if (hit) begin
            status_next = ST_DUPLICATE;
          end else begin
            status_next = ST_INSERTED;
            ctrl.append = 1'b1;
            count_next  = count + 1'b1;
          end
        end else begin
          if (hit) begin
            status_next = ST_REMOVED;
            ctrl.shift  = 1'b1;
            count_next  = count - 1'b1;
          end else begin
            status_next = ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for unique_key_record_table: directed and random insert/remove words,
// results checked in order against a record table kept inside the bench.
// Depends on ukrt_pkg and the unique_key_record_table RTL.
module tb;
  import ukrt_pkg::*;

  localparam int CAPACITY     = 128;
  localparam int POOL_SIZE    = 160;    // more keys than slots, so fills always hit full
  localparam int QUIET_TAIL   = 150;    // last words go out back to back
  localparam int DRAIN_CYCLES = 8;      // idle wait for a stray result word at the end
  localparam int CYCLE_LIMIT  = 200000; // watchdog limit for the whole run

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_word_t  cmd   = '0;
  logic      busy;
  logic      done;
  out_word_t result;

  unique_key_record_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #10 clk = ~clk;

  // Bench copy of the table. Values never show up on the result port, so only
  // keys and the count are tracked.
  logic [KEY_W-1:0] rec_key [CAPACITY];
  int unsigned      rec_count = 0;

  in_word_t         cmd_backlog[$];   // words not yet taken by the block
  out_word_t        replies_due[$];   // predicted result words, oldest first
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned n_errors  = 0;
  int unsigned n_taken   = 0;
  int unsigned gap_left  = 0;
  int unsigned idle_pct  = 0;
  int unsigned cycle_cnt = 0;

  // Applies one command word to the bench table and returns the reply word.
  // Full is checked before duplicate, so a full table refuses a present key as full.
  function automatic out_word_t apply_record_op(in_word_t w);
    out_word_t   r;
    int unsigned slot;
    slot = rec_count;
    for (int unsigned i = 0; i < rec_count; i++)
      if (slot == rec_count && rec_key[i] == w.key) slot = i;
    if (w.func == FUNC_INSERT) begin
      if (rec_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (slot < rec_count) begin
        r.status = ST_DUPLICATE;
      end else begin
        rec_key[rec_count] = w.key;
        rec_count++;
        r.status = ST_INSERTED;
      end
    end else if (slot < rec_count) begin
      // close the gap: later entries move down one place
      for (int unsigned j = slot; j + 1 < rec_count; j++) rec_key[j] = rec_key[j+1];
      rec_count--;
      r.status = ST_REMOVED;
    end else begin
      r.status = ST_NOTFOUND;
    end
    r.count_after = CNTO_W'(rec_count);
    return r;
  endfunction

  task automatic push_word(logic func, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    in_word_t w;
    w.func  = func;
    w.key   = key;
    w.value = value;
    cmd_backlog.push_back(w);
  endtask

  // Every pool key once, in shuffled order, then the first key again: after an
  // insert pass that is an insert into a full table of a key already stored,
  // after a remove pass a remove of a key already gone.
  task automatic add_pool_pass(logic func);
    int unsigned order [POOL_SIZE];
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < POOL_SIZE; i++) order[i] = i;
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) push_word(func, key_pool[order[i]], $urandom);
    push_word(func, key_pool[order[0]], $urandom);
  endtask

  // Pool keys with an insert bias, plus about 10% words with fully random fields.
  task automatic add_mix(int unsigned ins_pct, int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < 10)
        push_word(1'($urandom_range(1)), $urandom, $urandom);
      else
        push_word(($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE,
                  key_pool[$urandom_range(POOL_SIZE-1)], $urandom);
    end
  endtask

  // Driver: the word on cmd is taken at an edge with start high and busy low.
  // While busy holds it off, start and cmd stay put. After each take the
  // sender may go quiet before the next word; the idle rate changes every
  // 64 words (0, 25 or 50 percent) and is zero for the tail of the run.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        replies_due.push_back(apply_record_op(cmd));
        void'(cmd_backlog.pop_front());
        n_taken++;
        if (n_taken % 64 == 0) idle_pct = $urandom_range(2) * 25;
        if (cmd_backlog.size() > QUIET_TAIL && $urandom_range(99) < idle_pct)
          gap_left = $urandom_range(6, 1);
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        start <= 1'b1;
        cmd   <= cmd_backlog[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: done marks a result word for exactly one cycle; no back-pressure.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result word: status %0d count_after %0d",
               result.status, result.count_after);
        n_errors++;
      end else begin
        want = replies_due.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          n_errors++;
        end
        if (result.count_after !== want.count_after) begin
          $error("count_after: expected %0d, actual %0d", want.count_after, result.count_after);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;

    // Directed: key and value extremes, both operations, hits at the first,
    // middle and last slot, duplicates, misses on an empty and a loaded table.
    push_word(FUNC_REMOVE, '0, '0);                     // remove from empty table
    push_word(FUNC_INSERT, '0, '0);
    push_word(FUNC_INSERT, '1, '1);
    push_word(FUNC_INSERT, '0, 32'h1234_5678);          // duplicate of all-zero key
    push_word(FUNC_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    push_word(FUNC_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    push_word(FUNC_REMOVE, '1, '1);                     // middle hit, two entries shift
    push_word(FUNC_REMOVE, '1, '0);                     // already gone
    push_word(FUNC_INSERT, '1, 32'h0F0F_0F0F);
    push_word(FUNC_REMOVE, '0, '1);                     // first slot; value ignored
    push_word(FUNC_REMOVE, '1, '0);                     // last slot
    push_word(FUNC_INSERT, 32'hAAAA_AAAA, '0);          // duplicate
    push_word(FUNC_REMOVE, 32'h5555_5555, '0);
    push_word(FUNC_REMOVE, 32'hAAAA_AAAA, '0);          // table empty again
    push_word(FUNC_REMOVE, 32'hAAAA_AAAB, '0);          // miss on empty table

    // Random: fill to full, churn, sweep out, repeat with other insert biases.
    add_pool_pass(FUNC_INSERT);
    add_mix(50, 250);
    add_pool_pass(FUNC_REMOVE);
    add_mix(70, 200);
    add_pool_pass(FUNC_INSERT);
    add_mix(30, 250);
    add_pool_pass(FUNC_REMOVE);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray result word

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
